### rtl/call_line_state_switch_top_defines.svh
// Assertion macros used by the call line state switch sequencer.
`ifndef CALL_LINE_STATE_SWITCH_TOP_DEFINES_SVH
`define CALL_LINE_STATE_SWITCH_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CLS_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CLS_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define CLS_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cls_pkg.sv
// Types, codes and helpers of the call line state switch.
package cls_pkg;

    typedef logic [2:0] action_t;
    typedef logic [2:0] note_t;
    typedef logic [1:0] status_t;

    // Action codes
    localparam action_t ACT_REGISTER   = 3'd0;
    localparam action_t ACT_UNREGISTER = 3'd1;
    localparam action_t ACT_PICKUP     = 3'd2;
    localparam action_t ACT_HANGUP     = 3'd3;
    localparam action_t ACT_DIAL       = 3'd4;

    // Notice codes, also used as line states
    localparam note_t NOTE_NONE      = 3'd0;
    localparam note_t NOTE_ON_HOOK   = 3'd1;
    localparam note_t NOTE_RINGING   = 3'd2;
    localparam note_t NOTE_DIAL_TONE = 3'd3;
    localparam note_t NOTE_RING_BACK = 3'd4;
    localparam note_t NOTE_BUSY      = 3'd5;
    localparam note_t NOTE_CONNECTED = 3'd6;
    localparam note_t NOTE_ERROR     = 3'd7;

    // Status codes
    localparam status_t STAT_OK         = 2'd0;
    localparam status_t STAT_FULL       = 2'd1;
    localparam status_t STAT_NOT_REG    = 2'd2;
    localparam status_t STAT_BAD_ACTION = 2'd3;

    typedef struct packed {
        action_t    action;
        logic [5:0] unit;
        logic [5:0] dialed_ext;
    } in_item_t;

    typedef struct packed {
        logic [5:0] target_ext;
        note_t      notice;
        logic       carries_ext;
        logic [5:0] shown_ext;
        status_t    status;
        logic       last;
    } out_item_t;

    // One planned write to the line tables
    typedef struct packed {
        logic  en;
        logic  use_en;
        logic  use_val;
        note_t st;
    } wr_op_t;

    // Write enables of the three line tables
    typedef struct packed {
        logic use_we;
        logic st_we;
        logic pt_we;
    } mem_we_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RD_U,
        ST_RD_D,
        ST_WR0,
        ST_WR1,
        ST_EMIT0,
        ST_EMIT1
    } seq_state_t;

    // Build a notification word; the shown extension is zero without carry
    function automatic out_item_t mk_item(input logic [5:0] target, input note_t note,
                                          input logic carry, input logic [5:0] shown,
                                          input status_t status);
        out_item_t item;
        item.target_ext  = target;
        item.notice      = note;
        item.carries_ext = carry;
        item.shown_ext   = carry ? shown : 6'd0;
        item.status      = status;
        item.last        = 1'b0;
        return item;
    endfunction

endpackage

### rtl/cls_ram.sv
// Single-port-write, single-port-read table with registered read data.
module cls_ram
    import cls_pkg::*;
#(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry when enabled, read one entry every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/cls_seq.sv
// Sequencer of the call line state switch: clears, scans and updates the line tables.
`include "call_line_state_switch_top_defines.svh"

module cls_seq
    import cls_pkg::*;
#(
    parameter int unsigned NUM_EXTENSIONS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  in_item_t                          in_data,
    input  logic                              shutting_down,
    output logic [$clog2(NUM_EXTENSIONS)-1:0] raddr,
    output logic [$clog2(NUM_EXTENSIONS)-1:0] waddr,
    output mem_we_t                           mem_we,
    output logic                              wr_use,
    output note_t                             wr_st,
    output logic [$clog2(NUM_EXTENSIONS)-1:0] wr_pt,
    input  logic                              rd_use,
    input  note_t                             rd_st,
    input  logic [$clog2(NUM_EXTENSIONS)-1:0] rd_pt,
    output logic                              emit_valid,
    input  logic                              emit_ready,
    output out_item_t                         emit_item
);

    localparam int unsigned AW = $clog2(NUM_EXTENSIONS);
    localparam int unsigned CW = $clog2(NUM_EXTENSIONS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_EXTENSIONS - 1);

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0] search_start_reg, search_start_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic          chk_last_reg, chk_last_next;
    action_t       action_reg, action_next;
    logic [AW-1:0] u_addr_reg, u_addr_next;
    logic [AW-1:0] d_addr_reg, d_addr_next;
    logic          d_ok_reg, d_ok_next;
    wr_op_t        wr0_reg, wr0_next;
    wr_op_t        wr1_reg, wr1_next;
    logic [AW-1:0] wr0_addr_reg, wr0_addr_next;
    logic [AW-1:0] wr1_addr_reg, wr1_addr_next;
    logic          pw_en_reg, pw_en_next;
    out_item_t     res0_reg, res0_next;
    out_item_t     res1_reg, res1_next;
    logic          res1_vld_reg, res1_vld_next;

    logic          unit_ok;
    logic          dial_ok;
    logic [5:0]    u6;
    logic [5:0]    d6;
    logic [5:0]    p6;

    // Step an extension index round robin
    function automatic logic [AW-1:0] next_ext(input logic [AW-1:0] x);
        return (x == LAST_ADDR) ? '0 : x + AW'(1);
    endfunction

    assign unit_ok  = (32'(in_data.unit) < NUM_EXTENSIONS);
    assign dial_ok  = (32'(in_data.dialed_ext) < NUM_EXTENSIONS);
    assign u6       = 6'(u_addr_reg);
    assign d6       = 6'(d_addr_reg);
    assign p6       = 6'(rd_pt);
    assign in_stall = (state_reg != ST_IDLE);

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            search_start_reg <= '0;
            scan_cnt_reg     <= '0;
            chk_vld_reg      <= 1'b0;
            chk_last_reg     <= 1'b0;
            wr0_reg          <= '0;
            wr1_reg          <= '0;
            pw_en_reg        <= 1'b0;
            res1_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            search_start_reg <= search_start_next;
            scan_cnt_reg     <= scan_cnt_next;
            chk_vld_reg      <= chk_vld_next;
            chk_last_reg     <= chk_last_next;
            wr0_reg          <= wr0_next;
            wr1_reg          <= wr1_next;
            pw_en_reg        <= pw_en_next;
            res1_vld_reg     <= res1_vld_next;
        end
    end

    // Hold the word under work and its planned results
    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        action_reg    <= action_next;
        u_addr_reg    <= u_addr_next;
        d_addr_reg    <= d_addr_next;
        d_ok_reg      <= d_ok_next;
        wr0_addr_reg  <= wr0_addr_next;
        wr1_addr_reg  <= wr1_addr_next;
        res0_reg      <= res0_next;
        res1_reg      <= res1_next;
    end

    // Sequence one word: decode, read the tables, plan, write, emit
    always_comb
    begin
        logic told;
        told              = 1'b0;
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        search_start_next = search_start_reg;
        scan_addr_next    = scan_addr_reg;
        scan_cnt_next     = scan_cnt_reg;
        chk_addr_next     = chk_addr_reg;
        chk_vld_next      = chk_vld_reg;
        chk_last_next     = chk_last_reg;
        action_next       = action_reg;
        u_addr_next       = u_addr_reg;
        d_addr_next       = d_addr_reg;
        d_ok_next         = d_ok_reg;
        wr0_next          = wr0_reg;
        wr1_next          = wr1_reg;
        wr0_addr_next     = wr0_addr_reg;
        wr1_addr_next     = wr1_addr_reg;
        pw_en_next        = pw_en_reg;
        res0_next         = res0_reg;
        res1_next         = res1_reg;
        res1_vld_next     = res1_vld_reg;
        raddr             = u_addr_reg;
        waddr             = wr0_addr_reg;
        mem_we            = '0;
        wr_use            = 1'b0;
        wr_st             = NOTE_ON_HOOK;
        wr_pt             = wr1_addr_reg;
        emit_valid        = 1'b0;
        emit_item         = res0_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every entry to free and on hook
                waddr         = clr_cnt_reg;
                mem_we.use_we = 1'b1;
                mem_we.st_we  = 1'b1;
                clr_cnt_next  = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                raddr = AW'(in_data.unit);
                if (in_valid)
                begin
                    action_next   = in_data.action;
                    u_addr_next   = AW'(in_data.unit);
                    d_addr_next   = AW'(in_data.dialed_ext);
                    d_ok_next     = dial_ok;
                    wr0_next      = '0;
                    wr1_next      = '0;
                    pw_en_next    = 1'b0;
                    res1_vld_next = 1'b0;
                    if (in_data.action == ACT_REGISTER)
                    begin
                        scan_addr_next = search_start_reg;
                        scan_cnt_next  = '0;
                        chk_vld_next   = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else if (in_data.action inside {[3'd5:3'd7]})
                    begin
                        res0_next  = mk_item(in_data.unit, NOTE_NONE, 1'b0, 6'd0,
                                             STAT_BAD_ACTION);
                        state_next = ST_EMIT0;
                    end
                    else if (!unit_ok)
                    begin
                        res0_next  = mk_item(in_data.unit, NOTE_NONE, 1'b0, 6'd0,
                                             STAT_NOT_REG);
                        state_next = ST_EMIT0;
                    end
                    else
                    begin
                        state_next = ST_RD_U;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read a cycle, check the entry read last cycle
                raddr = scan_addr_reg;
                if (scan_cnt_reg < CW'(NUM_EXTENSIONS))
                begin
                    scan_addr_next = next_ext(scan_addr_reg);
                    scan_cnt_next  = scan_cnt_reg + CW'(1);
                    chk_addr_next  = scan_addr_reg;
                    chk_vld_next   = 1'b1;
                    chk_last_next  = (scan_cnt_reg == CW'(NUM_EXTENSIONS - 1));
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (!rd_use)
                    begin
                        wr0_next          = '{en: 1'b1, use_en: 1'b1, use_val: 1'b1,
                                              st: NOTE_ON_HOOK};
                        wr0_addr_next     = chk_addr_reg;
                        search_start_next = next_ext(search_start_reg);
                        res0_next         = mk_item(6'(chk_addr_reg), NOTE_ON_HOOK, 1'b1,
                                                    6'(chk_addr_reg), STAT_OK);
                        state_next        = ST_WR0;
                    end
                    else if (chk_last_reg)
                    begin
                        res0_next  = mk_item(6'd0, NOTE_NONE, 1'b0, 6'd0, STAT_FULL);
                        state_next = ST_EMIT0;
                    end
                end
            end

            ST_RD_U:
            begin
                // Entry of the unit is on the read port; fetch the dialed one next
                raddr      = d_addr_reg;
                state_next = ST_WR0;
                if (!rd_use)
                begin
                    res0_next  = mk_item(u6, NOTE_NONE, 1'b0, 6'd0, STAT_NOT_REG);
                    state_next = ST_EMIT0;
                end
                else
                begin
                    case (action_reg)
                        ACT_UNREGISTER:
                        begin
                            if (rd_st == NOTE_CONNECTED || rd_st == NOTE_RINGING)
                            begin
                                wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_DIAL_TONE};
                                wr0_addr_next = rd_pt;
                                if (!shutting_down)
                                begin
                                    res0_next = mk_item(p6, NOTE_DIAL_TONE, 1'b0, 6'd0,
                                                        STAT_OK);
                                    told      = 1'b1;
                                end
                            end
                            else if (rd_st == NOTE_RING_BACK)
                            begin
                                wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_ON_HOOK};
                                wr0_addr_next = rd_pt;
                                if (!shutting_down)
                                begin
                                    res0_next = mk_item(p6, NOTE_ON_HOOK, 1'b1, p6, STAT_OK);
                                    told      = 1'b1;
                                end
                            end
                            wr1_next      = '{en: 1'b1, use_en: 1'b1, use_val: 1'b0,
                                              st: NOTE_ON_HOOK};
                            wr1_addr_next = u_addr_reg;
                            if (!told)
                            begin
                                res0_next = mk_item(u6, NOTE_NONE, 1'b0, 6'd0, STAT_OK);
                            end
                        end

                        ACT_PICKUP:
                        begin
                            if (rd_st == NOTE_ON_HOOK)
                            begin
                                wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_DIAL_TONE};
                                wr0_addr_next = u_addr_reg;
                                res0_next     = mk_item(u6, NOTE_DIAL_TONE, 1'b0, 6'd0,
                                                        STAT_OK);
                            end
                            else if (rd_st == NOTE_RINGING)
                            begin
                                wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_CONNECTED};
                                wr0_addr_next = u_addr_reg;
                                wr1_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_CONNECTED};
                                wr1_addr_next = rd_pt;
                                res0_next     = mk_item(u6, NOTE_CONNECTED, 1'b1, p6, STAT_OK);
                                res1_next     = mk_item(p6, NOTE_CONNECTED, 1'b1, u6, STAT_OK);
                                res1_vld_next = 1'b1;
                            end
                            else
                            begin
                                res0_next = mk_item(u6, rd_st, 1'b0, 6'd0, STAT_OK);
                            end
                        end

                        ACT_HANGUP:
                        begin
                            wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                              st: NOTE_ON_HOOK};
                            wr0_addr_next = u_addr_reg;
                            res0_next     = mk_item(u6, NOTE_ON_HOOK, 1'b1, u6, STAT_OK);
                            if (rd_st == NOTE_CONNECTED || rd_st == NOTE_RINGING)
                            begin
                                wr1_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_DIAL_TONE};
                                wr1_addr_next = rd_pt;
                                res1_next     = mk_item(p6, NOTE_DIAL_TONE, 1'b0, 6'd0,
                                                        STAT_OK);
                                res1_vld_next = 1'b1;
                            end
                            else if (rd_st == NOTE_RING_BACK)
                            begin
                                wr1_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_ON_HOOK};
                                wr1_addr_next = rd_pt;
                                res1_next     = mk_item(p6, NOTE_ON_HOOK, 1'b1, p6, STAT_OK);
                                res1_vld_next = 1'b1;
                            end
                        end

                        ACT_DIAL:
                        begin
                            if (rd_st == NOTE_ON_HOOK)
                            begin
                                res0_next = mk_item(u6, NOTE_ON_HOOK, 1'b1, u6, STAT_OK);
                            end
                            else if (rd_st != NOTE_DIAL_TONE)
                            begin
                                res0_next = mk_item(u6, rd_st, 1'b0, 6'd0, STAT_OK);
                            end
                            else if (!d_ok_reg)
                            begin
                                wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                                  st: NOTE_ERROR};
                                wr0_addr_next = u_addr_reg;
                                res0_next     = mk_item(u6, NOTE_ERROR, 1'b0, 6'd0, STAT_OK);
                            end
                            else
                            begin
                                state_next = ST_RD_D;
                            end
                        end

                        default:
                        begin
                            res0_next  = mk_item(u6, NOTE_NONE, 1'b0, 6'd0, STAT_BAD_ACTION);
                            state_next = ST_EMIT0;
                        end
                    endcase
                end
            end

            ST_RD_D:
            begin
                // Entry of the dialed extension is on the read port
                state_next    = ST_WR0;
                wr0_addr_next = u_addr_reg;
                if (!rd_use)
                begin
                    wr0_next  = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0, st: NOTE_ERROR};
                    res0_next = mk_item(u6, NOTE_ERROR, 1'b0, 6'd0, STAT_OK);
                end
                else if (d_addr_reg == u_addr_reg || rd_st != NOTE_ON_HOOK)
                begin
                    wr0_next  = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0, st: NOTE_BUSY};
                    res0_next = mk_item(u6, NOTE_BUSY, 1'b0, 6'd0, STAT_OK);
                end
                else
                begin
                    wr0_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                      st: NOTE_RING_BACK};
                    wr1_next      = '{en: 1'b1, use_en: 1'b0, use_val: 1'b0,
                                      st: NOTE_RINGING};
                    wr1_addr_next = d_addr_reg;
                    pw_en_next    = 1'b1;
                    res0_next     = mk_item(u6, NOTE_RING_BACK, 1'b0, 6'd0, STAT_OK);
                    res1_next     = mk_item(d6, NOTE_RINGING, 1'b0, 6'd0, STAT_OK);
                    res1_vld_next = 1'b1;
                end
            end

            ST_WR0:
            begin
                waddr         = wr0_addr_reg;
                mem_we.use_we = wr0_reg.en & wr0_reg.use_en;
                mem_we.st_we  = wr0_reg.en;
                mem_we.pt_we  = wr0_reg.en & pw_en_reg;
                wr_use        = wr0_reg.use_val;
                wr_st         = wr0_reg.st;
                wr_pt         = wr1_addr_reg;
                state_next    = ST_WR1;
            end

            ST_WR1:
            begin
                waddr         = wr1_addr_reg;
                mem_we.use_we = wr1_reg.en & wr1_reg.use_en;
                mem_we.st_we  = wr1_reg.en;
                mem_we.pt_we  = wr1_reg.en & pw_en_reg;
                wr_use        = wr1_reg.use_val;
                wr_st         = wr1_reg.st;
                wr_pt         = wr0_addr_reg;
                state_next    = ST_EMIT0;
            end

            ST_EMIT0:
            begin
                emit_valid     = 1'b1;
                emit_item      = res0_reg;
                emit_item.last = !res1_vld_reg;
                if (emit_ready)
                begin
                    state_next = res1_vld_reg ? ST_EMIT1 : ST_IDLE;
                end
            end

            ST_EMIT1:
            begin
                emit_valid     = 1'b1;
                emit_item      = res1_reg;
                emit_item.last = 1'b1;
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CLS_IMPLY_NEXT(a_last_ends_word, emit_valid && emit_ready && emit_item.last, state_reg == ST_IDLE, "word not closed after last result")
    `CLS_IMPLY(a_second_planned, state_reg == ST_EMIT1, res1_vld_reg, "second result without plan")
    `CLS_IMPLY_NEXT(a_pointer_moves_in_scan, state_reg != ST_SCAN, $stable(search_start_reg), "search pointer moved outside scan")
    `CLS_CHECK(a_pointer_in_range, 32'(search_start_reg) < NUM_EXTENSIONS, "search pointer out of range")

endmodule

### rtl/call_line_state_switch_top.sv
// Top level of the call line state switch: line tables, sequencer, result register.
//
// Call line state switch for NUM_EXTENSIONS extensions. Each input word is an
// action (register, unregister, pickup, hangup, dial) and gives one or two
// notification words, the final one marked by last. Words are taken one at a
// time: in_stall is low only while the sequencer is idle. For unregister,
// pickup, hangup and dial on a registered unit a word passes the idle state
// that takes it, a table read of the unit, a read of the dialed extension for
// dial, two write slots and one emit state per result. A bad action or a unit
// beyond the switch goes straight from idle to emit, an unregistered unit
// after the read of the unit. Register scans the in-use table from the search
// pointer one entry per cycle through its read port. A result waits while the
// result register is full and stalled. After reset a clearing pass frees every
// entry before the first word is taken; shutting_down may be written at any
// time the block is idle.
module call_line_state_switch_top
    import cls_pkg::*;
#(
    parameter int unsigned NUM_EXTENSIONS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    localparam int unsigned AW = $clog2(NUM_EXTENSIONS);

    logic          shutting_down_reg;
    logic          out_valid_reg;
    out_item_t     out_data_reg;

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    mem_we_t       mem_we;
    logic          wr_use;
    note_t         wr_st;
    logic [AW-1:0] wr_pt;
    logic          rd_use;
    note_t         rd_st;
    logic [AW-1:0] rd_pt;
    logic          emit_valid;
    logic          emit_ready;
    out_item_t     emit_item;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shutting_down_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            shutting_down_reg <= cfg_wr_data;
        end
    end

    // Load a result word when the register is free or being drained
    assign emit_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_valid && emit_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            out_data_reg <= emit_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cls_seq #(
        .NUM_EXTENSIONS(NUM_EXTENSIONS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .shutting_down(shutting_down_reg),
        .raddr        (raddr),
        .waddr        (waddr),
        .mem_we       (mem_we),
        .wr_use       (wr_use),
        .wr_st        (wr_st),
        .wr_pt        (wr_pt),
        .rd_use       (rd_use),
        .rd_st        (rd_st),
        .rd_pt        (rd_pt),
        .emit_valid   (emit_valid),
        .emit_ready   (emit_ready),
        .emit_item    (emit_item)
    );

    // In-use marks
    cls_ram #(
        .WIDTH(1),
        .DEPTH(NUM_EXTENSIONS)
    ) u_use_ram (
        .clk  (clk),
        .we   (mem_we.use_we),
        .waddr(waddr),
        .wdata(wr_use),
        .raddr(raddr),
        .rdata(rd_use)
    );

    // Line states
    cls_ram #(
        .WIDTH(3),
        .DEPTH(NUM_EXTENSIONS)
    ) u_st_ram (
        .clk  (clk),
        .we   (mem_we.st_we),
        .waddr(waddr),
        .wdata(wr_st),
        .raddr(raddr),
        .rdata(rd_st)
    );

    // Partner extensions
    cls_ram #(
        .WIDTH(AW),
        .DEPTH(NUM_EXTENSIONS)
    ) u_pt_ram (
        .clk  (clk),
        .we   (mem_we.pt_we),
        .waddr(waddr),
        .wdata(wr_pt),
        .raddr(raddr),
        .rdata(rd_pt)
    );

endmodule

### sim/call_line_state_switch_top_test.sv
// Testbench of the call line state switch: scoreboard class, word drivers and result checks.
`timescale 1ns / 100ps

module call_line_state_switch_top_test;
    import cls_pkg::*;

    localparam int NUM_EXT       = 64;
    localparam int TOTAL_WORDS   = 1150;
    localparam int PHASE_WORDS   = 100;
    localparam int SETTLE_CYCLES = NUM_EXT + 8;
    localparam int MAX_PRINTS    = 100;

    // Action codes the block rejects
    localparam action_t ACT_BAD_LO = 3'd5;
    localparam action_t ACT_BAD_HI = 3'd7;

    // Line tables of the switch and the notices still owed by the block
    class switch_scoreboard;
        bit         ext_used [NUM_EXT];
        note_t      ext_line [NUM_EXT];
        logic [5:0] ext_peer [NUM_EXT];
        logic [5:0] hunt_ptr;
        bit         quiet_release;
        out_item_t  notices_due [$];
        out_item_t  fresh [$];
        int         fails;

        function new();
            foreach (ext_used[i])
            begin
                ext_used[i] = 1'b0;
                ext_line[i] = NOTE_ON_HOOK;
                ext_peer[i] = '0;
            end
            hunt_ptr      = '0;
            quiet_release = 1'b0;
            fails         = 0;
        endfunction

        function int pending();
            return notices_due.size();
        endfunction

        // Queue one notice of the word being worked out
        function void add_notice(logic [5:0] target, note_t note, logic carry,
                                 logic [5:0] shown, status_t status);
            out_item_t n;
            n.target_ext  = target;
            n.notice      = note;
            n.carries_ext = carry;
            n.shown_ext   = carry ? shown : 6'd0;
            n.status      = status;
            n.last        = 1'b0;
            fresh.push_back(n);
        endfunction

        // Advance the line tables by one accepted word and owe its notices
        function void take_action(in_item_t w);
            logic [5:0] u;
            logic [5:0] d;
            logic [5:0] p;
            logic [5:0] slot;
            note_t      st;
            bit         found;
            fresh.delete();
            u  = w.unit;
            d  = w.dialed_ext;
            st = ext_line[u];
            p  = ext_peer[u];
            if (w.action == ACT_REGISTER)
            begin
                // hunt for a free extension from the pointer
                found = 1'b0;
                slot  = hunt_ptr;
                for (int k = 0; k < NUM_EXT && !found; k++)
                begin
                    if (!ext_used[slot])
                        found = 1'b1;
                    else
                        slot = slot + 6'd1;
                end
                if (found)
                begin
                    ext_used[slot] = 1'b1;
                    ext_line[slot] = NOTE_ON_HOOK;
                    hunt_ptr       = hunt_ptr + 6'd1;
                    add_notice(slot, NOTE_ON_HOOK, 1'b1, slot, STAT_OK);
                end
                else
                    add_notice(6'd0, NOTE_NONE, 1'b0, 6'd0, STAT_FULL);
            end
            else if (w.action > ACT_DIAL)
                add_notice(u, NOTE_NONE, 1'b0, 6'd0, STAT_BAD_ACTION);
            else if (!ext_used[u])
                add_notice(u, NOTE_NONE, 1'b0, 6'd0, STAT_NOT_REG);
            else
            begin
                case (w.action)
                    ACT_UNREGISTER:
                    begin
                        // release the partner, quietly while shutting down
                        if (st == NOTE_CONNECTED || st == NOTE_RINGING)
                        begin
                            ext_line[p] = NOTE_DIAL_TONE;
                            if (!quiet_release)
                                add_notice(p, NOTE_DIAL_TONE, 1'b0, 6'd0, STAT_OK);
                        end
                        else if (st == NOTE_RING_BACK)
                        begin
                            ext_line[p] = NOTE_ON_HOOK;
                            if (!quiet_release)
                                add_notice(p, NOTE_ON_HOOK, 1'b1, p, STAT_OK);
                        end
                        ext_used[u] = 1'b0;
                        ext_line[u] = NOTE_ON_HOOK;
                        if (fresh.size() == 0)
                            add_notice(u, NOTE_NONE, 1'b0, 6'd0, STAT_OK);
                    end
                    ACT_PICKUP:
                    begin
                        if (st == NOTE_ON_HOOK)
                        begin
                            ext_line[u] = NOTE_DIAL_TONE;
                            add_notice(u, NOTE_DIAL_TONE, 1'b0, 6'd0, STAT_OK);
                        end
                        else if (st == NOTE_RINGING)
                        begin
                            ext_line[u] = NOTE_CONNECTED;
                            ext_line[p] = NOTE_CONNECTED;
                            add_notice(u, NOTE_CONNECTED, 1'b1, p, STAT_OK);
                            add_notice(p, NOTE_CONNECTED, 1'b1, u, STAT_OK);
                        end
                        else
                            add_notice(u, st, 1'b0, 6'd0, STAT_OK);
                    end
                    ACT_HANGUP:
                    begin
                        ext_line[u] = NOTE_ON_HOOK;
                        add_notice(u, NOTE_ON_HOOK, 1'b1, u, STAT_OK);
                        if (st == NOTE_CONNECTED || st == NOTE_RINGING)
                        begin
                            ext_line[p] = NOTE_DIAL_TONE;
                            add_notice(p, NOTE_DIAL_TONE, 1'b0, 6'd0, STAT_OK);
                        end
                        else if (st == NOTE_RING_BACK)
                        begin
                            ext_line[p] = NOTE_ON_HOOK;
                            add_notice(p, NOTE_ON_HOOK, 1'b1, p, STAT_OK);
                        end
                    end
                    default:
                    begin
                        // dial: only a line with dial tone moves
                        if (st == NOTE_ON_HOOK)
                            add_notice(u, NOTE_ON_HOOK, 1'b1, u, STAT_OK);
                        else if (st != NOTE_DIAL_TONE)
                            add_notice(u, st, 1'b0, 6'd0, STAT_OK);
                        else if (!ext_used[d])
                        begin
                            ext_line[u] = NOTE_ERROR;
                            add_notice(u, NOTE_ERROR, 1'b0, 6'd0, STAT_OK);
                        end
                        else if (d == u || ext_line[d] != NOTE_ON_HOOK)
                        begin
                            ext_line[u] = NOTE_BUSY;
                            add_notice(u, NOTE_BUSY, 1'b0, 6'd0, STAT_OK);
                        end
                        else
                        begin
                            ext_line[u] = NOTE_RING_BACK;
                            ext_line[d] = NOTE_RINGING;
                            ext_peer[u] = d;
                            ext_peer[d] = u;
                            add_notice(u, NOTE_RING_BACK, 1'b0, 6'd0, STAT_OK);
                            add_notice(d, NOTE_RINGING, 1'b0, 6'd0, STAT_OK);
                        end
                    end
                endcase
            end
            fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                notices_due.push_back(fresh[i]);
        endfunction

        task report_mismatch(string what);
            if (fails < MAX_PRINTS)
                $display("%0t: error: %s", $time, what);
            fails++;
        endtask

        // Compare one delivered notice with the oldest one owed
        task check_notice(out_item_t got);
            out_item_t want;
            if (notices_due.size() == 0)
                report_mismatch($sformatf("notice word %h with none owed", got));
            else
            begin
                want = notices_due.pop_front();
                if (got.target_ext !== want.target_ext)
                    report_mismatch($sformatf("target_ext %0d, owed %0d",
                                              got.target_ext, want.target_ext));
                if (got.notice !== want.notice)
                    report_mismatch($sformatf("notice %0d, owed %0d at ext %0d",
                                              got.notice, want.notice, want.target_ext));
                if (got.carries_ext !== want.carries_ext)
                    report_mismatch($sformatf("carries_ext %0b, owed %0b at ext %0d",
                                              got.carries_ext, want.carries_ext,
                                              want.target_ext));
                if (got.shown_ext !== want.shown_ext)
                    report_mismatch($sformatf("shown_ext %0d, owed %0d at ext %0d",
                                              got.shown_ext, want.shown_ext,
                                              want.target_ext));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, owed %0d at ext %0d",
                                              got.status, want.status, want.target_ext));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0b, owed %0b at ext %0d",
                                              got.last, want.last, want.target_ext));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_wr_en;
    logic      cfg_wr_data;

    switch_scoreboard board;
    int words_sent;
    int burst_left;

    call_line_state_switch_top #(
        .NUM_EXTENSIONS(NUM_EXT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic in_item_t mk_word(action_t act, int u, int d);
        in_item_t w;
        w.action     = act;
        w.unit       = 6'(u);
        w.dialed_ext = 6'(d);
        return w;
    endfunction

    function automatic int rnd_ext();
        return int'($urandom_range(0, NUM_EXT - 1));
    endfunction

    // Pick a registered extension, on the hook if asked; -1 when none fits
    function automatic int pick_ext(bit want_idle);
        int start;
        int e;
        start = rnd_ext();
        for (int k = 0; k < NUM_EXT; k++)
        begin
            e = (start + k) % NUM_EXT;
            if (board.ext_used[e] && (!want_idle || board.ext_line[e] == NOTE_ON_HOOK))
                return e;
        end
        return -1;
    endfunction

    // Offer one word, hold it until taken, then pace the next burst
    task automatic send_word(input in_item_t w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_action(w);
        words_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 120))
                                                     : int'($urandom_range(1, 12));
            repeat ($urandom_range(1, 14))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                in_data  <= in_item_t'(15'($urandom));
            end
        end
    endtask

    // Drop valid and wait until every owed notice is in and the block is idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_quiet(input logic v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        board.quiet_release = v;
    endtask

    // One call attempt between two extensions with a random ending
    task automatic place_call();
        int a;
        int b;
        a = pick_ext(1'b1);
        b = ($urandom_range(0, 9) < 7) ? pick_ext(1'b1) : rnd_ext();
        if (a < 0)
            send_word(mk_word(ACT_REGISTER, rnd_ext(), rnd_ext()));
        else
        begin
            if (b < 0)
                b = rnd_ext();
            send_word(mk_word(ACT_PICKUP, a, rnd_ext()));
            send_word(mk_word(ACT_DIAL, a, b));
            case ($urandom_range(0, 5))
                0:
                begin
                    send_word(mk_word(ACT_PICKUP, b, rnd_ext()));
                    send_word(mk_word(ACT_HANGUP, a, rnd_ext()));
                end
                1:
                begin
                    send_word(mk_word(ACT_PICKUP, b, rnd_ext()));
                    send_word(mk_word(ACT_HANGUP, b, rnd_ext()));
                end
                2:
                begin
                    send_word(mk_word(ACT_PICKUP, b, rnd_ext()));
                    send_word(mk_word(ACT_UNREGISTER, $urandom_range(0, 1) ? a : b,
                                      rnd_ext()));
                end
                3:
                    send_word(mk_word(ACT_HANGUP, a, rnd_ext()));
                4:
                    send_word(mk_word(ACT_UNREGISTER, $urandom_range(0, 1) ? a : b,
                                      rnd_ext()));
                default:
                begin
                    send_word(mk_word(ACT_DIAL, b, a));
                    send_word(mk_word(ACT_PICKUP, b, rnd_ext()));
                    send_word(mk_word(ACT_PICKUP, a, rnd_ext()));
                    send_word(mk_word(ACT_DIAL, a, b));
                end
            endcase
            // put the caller back on the hook most of the time
            if ($urandom_range(0, 3) != 0)
                send_word(mk_word(ACT_HANGUP, a, rnd_ext()));
        end
    endtask

    // Check every notice the block hands over
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_notice(out_data);
    end

    // Stall the result side in stretches of differing patterns
    initial
    begin
        int  mode;
        int  span;
        int  hold;
        int  tick;
        bit  stall_now;
        out_stall = 1'b0;
        hold      = 0;
        tick      = 0;
        stall_now = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 300);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2:
                    begin
                        if (hold == 0)
                        begin
                            stall_now = !stall_now;
                            hold = stall_now ? int'($urandom_range(1, 12))
                                             : int'($urandom_range(1, 10));
                        end
                        hold--;
                        out_stall <= stall_now;
                    end
                    default: out_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Give up after a generous fixed time
    initial
    begin
        #3000000;
        $display("call_line_state_switch_top: mismatch");
        $finish;
    end

    initial
    begin
        int phase;
        int live;
        int r;
        int e;
        board       = new();
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        rst_n       = 1'b0;
        words_sent  = 0;
        burst_left  = $urandom_range(1, 12);
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hold off until the clearing pass is over
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        write_quiet(1'b0);

        // directed: rejects, registration, and line transitions by dial, pickup, hangup and unregister
        send_word(mk_word(ACT_DIAL, 63, 63));
        send_word(mk_word(ACT_BAD_HI, 63, 0));
        send_word(mk_word(ACT_BAD_LO, 0, 63));
        for (int k = 0; k < 4; k++)
            send_word(mk_word(ACT_REGISTER, (k == 0) ? 63 : k, 63 - k));
        send_word(mk_word(ACT_DIAL, 0, 1));
        send_word(mk_word(ACT_PICKUP, 0, 0));
        send_word(mk_word(ACT_PICKUP, 0, 0));
        send_word(mk_word(ACT_DIAL, 0, 0));
        send_word(mk_word(ACT_HANGUP, 0, 0));
        send_word(mk_word(ACT_PICKUP, 0, 0));
        send_word(mk_word(ACT_DIAL, 0, 63));
        send_word(mk_word(ACT_DIAL, 0, 1));
        send_word(mk_word(ACT_HANGUP, 0, 0));
        send_word(mk_word(ACT_PICKUP, 0, 0));
        send_word(mk_word(ACT_DIAL, 0, 1));
        send_word(mk_word(ACT_DIAL, 1, 0));
        send_word(mk_word(ACT_PICKUP, 1, 0));
        send_word(mk_word(ACT_HANGUP, 1, 0));
        send_word(mk_word(ACT_HANGUP, 0, 0));
        send_word(mk_word(ACT_PICKUP, 2, 0));
        send_word(mk_word(ACT_DIAL, 2, 3));
        send_word(mk_word(ACT_HANGUP, 2, 0));
        send_word(mk_word(ACT_PICKUP, 2, 0));
        send_word(mk_word(ACT_DIAL, 2, 3));
        send_word(mk_word(ACT_UNREGISTER, 3, 0));

        // random phases, each under its own release setting
        phase = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            settle();
            write_quiet((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            if (phase == 3)
            begin
                // fill the switch and keep asking past full
                repeat (NUM_EXT + 6)
                    send_word(mk_word(ACT_REGISTER, rnd_ext(), rnd_ext()));
            end
            else if (phase == 5)
            begin
                // sweep every extension off the switch
                for (int k = 0; k < NUM_EXT; k++)
                    send_word(mk_word(ACT_UNREGISTER, k, rnd_ext()));
            end
            else
            begin
                repeat (PHASE_WORDS)
                begin
                    live = 0;
                    foreach (board.ext_used[i])
                        live += board.ext_used[i];
                    r = $urandom_range(0, 99);
                    if (live < 8 || r < 10)
                        send_word(mk_word(ACT_REGISTER, rnd_ext(), rnd_ext()));
                    else if (r < 60)
                        place_call();
                    else if (r < 68)
                        send_word(mk_word(ACT_UNREGISTER, pick_ext(1'b0), rnd_ext()));
                    else if (r < 78)
                        send_word(mk_word(3'($urandom_range(0, 7)), rnd_ext(), rnd_ext()));
                    else if (r < 84)
                        send_word(mk_word(3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI)),
                                          rnd_ext(), rnd_ext()));
                    else
                    begin
                        e = $urandom_range(0, 1) ? pick_ext(1'b0) : rnd_ext();
                        send_word(mk_word(3'($urandom_range(ACT_UNREGISTER, ACT_DIAL)), e,
                                          $urandom_range(0, 1) ? pick_ext(1'b0) : rnd_ext()));
                    end
                end
            end
            phase++;
        end

        settle();
        if (board.fails == 0)
            $display("call_line_state_switch_top: match");
        else
            $display("call_line_state_switch_top: mismatch");
        $finish;
    end

endmodule
